/* rtl/aefk_pkg.sv */
package aefk_pkg;

   localparam int FREQ_W  = 24;
   localparam int PROD_W  = 30;
   localparam int DIG_W   = 8;
   localparam int CNT_W   = $clog2(DIG_W);
   localparam int ELAP_W  = 11;
   localparam int ACCEL_W = 4;
   localparam int STEP_W  = 8;
   localparam int MODE_W  = 2;
   localparam int CSR_W   = 24;
   localparam int PER_W   = 10;

   localparam logic [CNT_W-1:0]  CNT_LAST   = CNT_W'(DIG_W - 1);
   localparam logic [ELAP_W-1:0] ELAP_LIMIT = 11'd2047;
   localparam logic signed [STEP_W-1:0] STEP_LIMIT = 8'sd127;
   localparam logic [STEP_W-1:0] STEP_BOOST = 8'd2;
   localparam logic [MODE_W-1:0] MODE_LAST  = 2'd2;
   localparam logic [FREQ_W-1:0] FREQ_RESET = 24'd1000;

   localparam logic [1:0] FUNC_TICK   = 2'd0;
   localparam logic [1:0] FUNC_EDGE   = 2'd1;
   localparam logic [1:0] FUNC_BUTTON = 2'd2;
   localparam logic [1:0] FUNC_NONE   = 2'd3;

   localparam logic [1:0] CSR_POLL_PERIOD = 2'd0;
   localparam logic [1:0] CSR_ACCEL_MIN   = 2'd1;
   localparam logic [1:0] CSR_ACCEL_MAX   = 2'd2;
   localparam logic [1:0] CSR_FREQ_MAX    = 2'd3;

   localparam logic [PER_W-1:0]   POLL_PERIOD_RESET = 10'd50;
   localparam logic [ACCEL_W-1:0] ACCEL_MIN_RESET   = 4'd1;
   localparam logic [ACCEL_W-1:0] ACCEL_MAX_RESET   = 4'd10;
   localparam logic [FREQ_W-1:0]  FREQ_MAX_RESET    = 24'd9999999;

   typedef struct packed {
      logic              start;
      logic [PROD_W-1:0] mcand;
      logic [DIG_W-1:0]  mplier;
   } mul_req_type;

   typedef struct packed {
      logic              done;
      logic [PROD_W-1:0] product;
   } mul_rsp_type;

endpackage

/* rtl/aefk_mul.sv */
module aefk_mul
   import aefk_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  mul_req_type mul_req,
   output mul_rsp_type mul_rsp
);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [PROD_W-1:0] mcand_ff, mcand_in;
   logic [DIG_W-1:0]  mplier_ff, mplier_in;
   logic [PROD_W-1:0] acc_ff, acc_in;

   always_comb begin
      busy_in   = busy_ff;
      done_in   = 1'b0;
      cnt_in    = cnt_ff;
      mcand_in  = mcand_ff;
      mplier_in = mplier_ff;
      acc_in    = acc_ff;
      if (mul_req.start) begin
         busy_in   = 1'b1;
         cnt_in    = '0;
         mcand_in  = mul_req.mcand;
         mplier_in = mul_req.mplier;
         acc_in    = '0;
      end else if (busy_ff) begin
         if (mplier_ff[0]) begin
            acc_in = acc_ff + mcand_ff;
         end
         mcand_in  = mcand_ff << 1;
         mplier_in = mplier_ff >> 1;
         cnt_in    = cnt_ff + CNT_W'(1);
         if (cnt_ff == CNT_LAST) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff    <= cnt_in;
      mcand_ff  <= mcand_in;
      mplier_ff <= mplier_in;
      acc_ff    <= acc_in;
   end

   assign mul_rsp.done    = done_ff;
   assign mul_rsp.product = acc_ff;

   assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !busy_ff)
      else $error("product reported while still stepping");

   assert property (@(posedge clock) disable iff (reset)
      (busy_ff && !mul_req.start && cnt_ff == CNT_LAST) |=> done_ff)
      else $error("last step did not report the product");

   assert property (@(posedge clock) disable iff (reset)
      mul_req.start |=> busy_ff && cnt_ff == '0)
      else $error("start did not load the unit");

endmodule

/* rtl/accelerated_encoder_frequency_knob_unit.sv */
// Rotary encoder frequency knob with acceleration.
// Input channel req_: one event per item, req_func selects a 1 ms tick, an
// encoder A falling edge (req_line_b_level gives the direction) or a button
// press. Result channel rsp_: one item per event with the frequency, the
// waveform mode, change flags and the acceleration level.
// Configuration port csr_: poll period, acceleration floor and ceiling and
// the frequency ceiling, written by index. The user must write them only
// while the block is idle; the block itself does not enforce it.
// Sequence: an event without a poll goes from acceptance to ST_FIN, which
// loads its result into the result register. A tick that polls a nonzero
// step count runs four passes of the bit-serial multiplier (count squared,
// cubed, times the factor twice), each a load, 8 steps and a handoff, before
// ST_FIN loads its result. Flow: one event in flight at a time; a new event
// is accepted only after the result of the last one is written. req_stall is
// high from acceptance until the result is written to the output register.
// A result held by rsp_stall does not block the next event; that event waits
// in its final cycle until the output register is free.
// Reset (synchronous, active high) restores the default registers, frequency
// 1000, mode sine, acceleration 1, zero steps and zero elapsed time.
module accelerated_encoder_frequency_knob_unit
   import aefk_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [1:0]          req_func,
   input  logic                req_line_b_level,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [FREQ_W-1:0]   rsp_frequency,
   output logic [MODE_W-1:0]   rsp_mode,
   output logic                rsp_freq_changed,
   output logic                rsp_mode_changed,
   output logic [ACCEL_W-1:0]  rsp_accel_level,
   input  logic                csr_write_enable,
   input  logic [1:0]          csr_index,
   input  logic [CSR_W-1:0]    csr_data
);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_MUL  = 3'b010,
      ST_FIN  = 3'b100
   } state_type;

   localparam logic [1:0] PH_SQUARE = 2'd0;
   localparam logic [1:0] PH_CUBE   = 2'd1;
   localparam logic [1:0] PH_ACCEL1 = 2'd2;
   localparam logic [1:0] PH_ACCEL2 = 2'd3;

   state_type state_ff, state_in;

   logic [PER_W-1:0]   poll_period_ff, poll_period_in;
   logic [ACCEL_W-1:0] accel_min_ff, accel_min_in;
   logic [ACCEL_W-1:0] accel_max_ff, accel_max_in;
   logic [FREQ_W-1:0]  freq_max_ff, freq_max_in;

   logic [ELAP_W-1:0]        elapsed_ff, elapsed_in;
   logic signed [STEP_W-1:0] step_ff, step_in;
   logic [ACCEL_W-1:0]       accel_ff, accel_in;
   logic [FREQ_W-1:0]        freq_ff, freq_in;
   logic [MODE_W-1:0]        mode_ff, mode_in;

   logic [STEP_W-1:0]  mag_ff, mag_in;
   logic               neg_ff, neg_in;
   logic               delta_zero_ff, delta_zero_in;
   logic [ACCEL_W-1:0] accel_used_ff, accel_used_in;
   logic               mode_adv_ff, mode_adv_in;
   logic [1:0]         phase_ff, phase_in;
   logic               start_ff, start_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [FREQ_W-1:0]  rsp_frequency_ff, rsp_frequency_in;
   logic [MODE_W-1:0]  rsp_mode_ff, rsp_mode_in;
   logic               rsp_freq_changed_ff, rsp_freq_changed_in;
   logic               rsp_mode_changed_ff, rsp_mode_changed_in;
   logic [ACCEL_W-1:0] rsp_accel_level_ff, rsp_accel_level_in;

   mul_req_type mul_req;
   mul_rsp_type mul_rsp;

   logic              accept;
   logic              slot_free;
   logic [ELAP_W-1:0] elapsed_inc;
   logic              poll;
   logic [STEP_W-1:0] step_abs;
   logic [STEP_W-1:0] step_mag;
   logic [PROD_W-1:0] delta;
   logic [PROD_W-1:0] freq_ext;
   logic [PROD_W:0]   clamp_pre;
   logic [FREQ_W-1:0] freq_new;

   aefk_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .mul_req (mul_req),
      .mul_rsp (mul_rsp)
   );

   assign accept    = req_valid && (state_ff == ST_IDLE);
   assign req_stall = (state_ff != ST_IDLE);
   assign slot_free = !rsp_valid_ff || !rsp_stall;

   assign elapsed_inc = (elapsed_ff == ELAP_LIMIT) ? elapsed_ff : elapsed_ff + ELAP_W'(1);
   assign poll        = elapsed_inc > ELAP_W'(poll_period_ff);
   assign step_abs    = step_ff[STEP_W-1] ? STEP_W'(-step_ff) : STEP_W'(step_ff);
   assign step_mag    = (step_abs > STEP_BOOST) ? step_abs + STEP_BOOST : step_abs;

   assign delta    = delta_zero_ff ? '0 : mul_rsp.product;
   assign freq_ext = PROD_W'(freq_ff);

   always_comb begin
      if (neg_ff) begin
         if (delta > freq_ext) begin
            clamp_pre = '0;
         end else begin
            clamp_pre = (PROD_W + 1)'(freq_ext - delta);
         end
      end else begin
         clamp_pre = (PROD_W + 1)'(freq_ext) + (PROD_W + 1)'(delta);
      end
      if (clamp_pre > (PROD_W + 1)'(freq_max_ff)) begin
         freq_new = freq_max_ff;
      end else begin
         freq_new = clamp_pre[FREQ_W-1:0];
      end
   end

   always_comb begin
      mul_req.start = start_ff;
      unique case (phase_ff)
         PH_SQUARE: begin
            mul_req.mcand  = PROD_W'(mag_ff);
            mul_req.mplier = mag_ff;
         end
         PH_CUBE: begin
            mul_req.mcand  = mul_rsp.product;
            mul_req.mplier = mag_ff;
         end
         PH_ACCEL1, PH_ACCEL2: begin
            mul_req.mcand  = mul_rsp.product;
            mul_req.mplier = DIG_W'(accel_used_ff);
         end
      endcase
   end

   always_comb begin
      poll_period_in = poll_period_ff;
      accel_min_in   = accel_min_ff;
      accel_max_in   = accel_max_ff;
      freq_max_in    = freq_max_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_POLL_PERIOD: poll_period_in = csr_data[PER_W-1:0];
            CSR_ACCEL_MIN:   accel_min_in   = csr_data[ACCEL_W-1:0];
            CSR_ACCEL_MAX:   accel_max_in   = csr_data[ACCEL_W-1:0];
            CSR_FREQ_MAX:    freq_max_in    = csr_data[FREQ_W-1:0];
         endcase
      end
   end

   always_comb begin
      state_in      = state_ff;
      elapsed_in    = elapsed_ff;
      step_in       = step_ff;
      accel_in      = accel_ff;
      freq_in       = freq_ff;
      mode_in       = mode_ff;
      mag_in        = mag_ff;
      neg_in        = neg_ff;
      delta_zero_in = delta_zero_ff;
      accel_used_in = accel_used_ff;
      mode_adv_in   = mode_adv_ff;
      phase_in      = phase_ff;
      start_in      = 1'b0;

      rsp_valid_in        = rsp_valid_ff && rsp_stall;
      rsp_frequency_in    = rsp_frequency_ff;
      rsp_mode_in         = rsp_mode_ff;
      rsp_freq_changed_in = rsp_freq_changed_ff;
      rsp_mode_changed_in = rsp_mode_changed_ff;
      rsp_accel_level_in  = rsp_accel_level_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               delta_zero_in = 1'b1;
               neg_in        = 1'b0;
               mode_adv_in   = 1'b0;
               state_in      = ST_FIN;
               unique case (req_func)
                  FUNC_TICK: begin
                     elapsed_in = elapsed_inc;
                     if (poll) begin
                        elapsed_in = '0;
                        if (step_ff == '0) begin
                           if (accel_ff > accel_min_ff) begin
                              accel_in = accel_ff - ACCEL_W'(1);
                           end
                        end else begin
                           mag_in        = step_mag;
                           neg_in        = step_ff[STEP_W-1];
                           delta_zero_in = 1'b0;
                           accel_used_in = accel_ff;
                           if (accel_ff < accel_max_ff) begin
                              accel_in = accel_ff + ACCEL_W'(1);
                           end
                           step_in  = '0;
                           phase_in = PH_SQUARE;
                           start_in = 1'b1;
                           state_in = ST_MUL;
                        end
                     end
                  end
                  FUNC_EDGE: begin
                     if (!req_line_b_level) begin
                        if (step_ff < STEP_LIMIT) begin
                           step_in = step_ff + STEP_W'(1);
                        end
                     end else if (step_ff > -STEP_LIMIT) begin
                        step_in = step_ff - STEP_W'(1);
                     end
                  end
                  FUNC_BUTTON: begin
                     mode_in     = (mode_ff >= MODE_LAST) ? '0 : mode_ff + MODE_W'(1);
                     mode_adv_in = 1'b1;
                  end
                  FUNC_NONE: begin
                  end
               endcase
            end
         end
         ST_MUL: begin
            if (mul_rsp.done) begin
               if (phase_ff == PH_ACCEL2) begin
                  state_in = ST_FIN;
               end else begin
                  phase_in = phase_ff + 2'd1;
                  start_in = 1'b1;
               end
            end
         end
         ST_FIN: begin
            if (slot_free) begin
               freq_in             = freq_new;
               rsp_valid_in        = 1'b1;
               rsp_frequency_in    = freq_new;
               rsp_mode_in         = mode_ff;
               rsp_freq_changed_in = (freq_new != freq_ff);
               rsp_mode_changed_in = mode_adv_ff;
               rsp_accel_level_in  = accel_ff;
               state_in            = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         poll_period_ff <= POLL_PERIOD_RESET;
         accel_min_ff   <= ACCEL_MIN_RESET;
         accel_max_ff   <= ACCEL_MAX_RESET;
         freq_max_ff    <= FREQ_MAX_RESET;
         elapsed_ff     <= '0;
         step_ff        <= '0;
         accel_ff       <= ACCEL_MIN_RESET;
         freq_ff        <= FREQ_RESET;
         mode_ff        <= '0;
         phase_ff       <= PH_SQUARE;
         start_ff       <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         poll_period_ff <= poll_period_in;
         accel_min_ff   <= accel_min_in;
         accel_max_ff   <= accel_max_in;
         freq_max_ff    <= freq_max_in;
         elapsed_ff     <= elapsed_in;
         step_ff        <= step_in;
         accel_ff       <= accel_in;
         freq_ff        <= freq_in;
         mode_ff        <= mode_in;
         phase_ff       <= phase_in;
         start_ff       <= start_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mag_ff              <= mag_in;
      neg_ff              <= neg_in;
      delta_zero_ff       <= delta_zero_in;
      accel_used_ff       <= accel_used_in;
      mode_adv_ff         <= mode_adv_in;
      rsp_frequency_ff    <= rsp_frequency_in;
      rsp_mode_ff         <= rsp_mode_in;
      rsp_freq_changed_ff <= rsp_freq_changed_in;
      rsp_mode_changed_ff <= rsp_mode_changed_in;
      rsp_accel_level_ff  <= rsp_accel_level_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_frequency    = rsp_frequency_ff;
   assign rsp_mode         = rsp_mode_ff;
   assign rsp_freq_changed = rsp_freq_changed_ff;
   assign rsp_mode_changed = rsp_mode_changed_ff;
   assign rsp_accel_level  = rsp_accel_level_ff;

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FIN && slot_free) |=> rsp_frequency_ff <= freq_max_ff)
      else $error("frequency written above its ceiling");

   assert property (@(posedge clock) disable iff (reset)
      mul_rsp.done |-> state_ff == ST_MUL)
      else $error("multiplier finished outside a poll");

   assert property (@(posedge clock) disable iff (reset)
      (mode_ff <= MODE_LAST) && (step_ff != -STEP_LIMIT - 8'sd1))
      else $error("mode or step count out of range");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MUL) |-> (step_ff == '0 && elapsed_ff == '0))
      else $error("poll did not clear the step count and timer");

endmodule
